[sv/dtd_pkg.sv]
// ---------------------------------------------------------------------------
// dtd_pkg: shared types and constants
// Byte codes, record kinds, status codes and the beat type between front/back.
// ---------------------------------------------------------------------------
`default_nettype none

package dtd_pkg;

	localparam int LENGTH_BITS_DEF = 24;
	localparam int QUEUE_DEPTH     = 2;
	localparam int MISS_LIMIT_RST  = 10;

	localparam logic [7:0] BYTE_START = 8'd2;
	localparam logic [7:0] BYTE_DELIM = 8'd31;
	localparam logic [7:0] BYTE_FIN   = 8'd3;
	localparam logic [7:0] BYTE_DATO  = 8'd4;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;

	// output field layout
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 3;
	localparam int PLEN_W   = 24;
	localparam int KIND_W   = 2;
	localparam int TDATA_W  = 40;

	localparam logic [KIND_W-1:0] KIND_BODY    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISS_LIMIT   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_DELIM    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FIN_NO_DELIM = 3'd3;
	localparam logic [STATUS_W-1:0] ST_PAYLOAD_MISS = 3'd4;

	// classified beat handed from front to back
	typedef struct packed {
		logic       miss;
		logic [7:0] rx_byte;
		logic       is_start;
		logic       is_delim;
		logic       is_fin;
		logic       is_dato;
		logic       is_digit;
		logic [3:0] digit;
	} beat_t;

endpackage

`default_nettype wire

[sv/dtd_front.sv]
// ---------------------------------------------------------------------------
// dtd_front: input classifier
// Accepts input beats and decodes the control bytes and decimal digits.
// ---------------------------------------------------------------------------
`default_nettype none

module dtd_front (
	input  wire logic            s_axis_tvalid,
	output logic                 s_axis_tready,
	input  wire logic [7:0]      s_axis_tdata,
	input  wire logic [0:0]      s_axis_tuser,
	input  wire logic            q_full,
	output logic                 q_push,
	output dtd_pkg::beat_t       q_wdata
);

	logic [7:0] digit_full;

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;
	assign digit_full    = s_axis_tdata - dtd_pkg::CHAR_ZERO;

	always_comb begin
		q_wdata          = '0;
		q_wdata.miss     = s_axis_tuser[0];
		q_wdata.rx_byte  = s_axis_tdata;
		q_wdata.is_start = (s_axis_tdata == dtd_pkg::BYTE_START);
		q_wdata.is_delim = (s_axis_tdata == dtd_pkg::BYTE_DELIM);
		q_wdata.is_fin   = (s_axis_tdata == dtd_pkg::BYTE_FIN);
		q_wdata.is_dato  = (s_axis_tdata == dtd_pkg::BYTE_DATO);
		q_wdata.is_digit = (s_axis_tdata >= dtd_pkg::CHAR_ZERO) &&
				(s_axis_tdata <= dtd_pkg::CHAR_NINE);
		q_wdata.digit    = digit_full[3:0];
	end

endmodule

`default_nettype wire

[sv/dtd_queue.sv]
// ---------------------------------------------------------------------------
// dtd_queue: short beat queue
// Small FIFO between classifier and parser; push and pop in the same cycle unless it is full.
// ---------------------------------------------------------------------------
`default_nettype none

module dtd_queue #(
	parameter int DEPTH = dtd_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire dtd_pkg::beat_t wdata,
	input  wire logic           pop,
	output logic                full,
	output logic                not_empty,
	output dtd_pkg::beat_t      rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	dtd_pkg::beat_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[sv/dtd_back.sv]
// ---------------------------------------------------------------------------
// dtd_back: telegram parser
// Phase machine over classified beats with a registered output record.
// ---------------------------------------------------------------------------
`default_nettype none

module dtd_back #(
	parameter int LENGTH_BITS = dtd_pkg::LENGTH_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [7:0]                    miss_limit,
	input  wire logic                          q_not_empty,
	input  wire dtd_pkg::beat_t                q_rdata,
	output logic                               q_pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [dtd_pkg::KIND_W-1:0]         out_kind,
	output logic [dtd_pkg::BYTE_W-1:0]         out_byte,
	output logic [dtd_pkg::STATUS_W-1:0]       out_status,
	output logic                               out_last,
	output logic [dtd_pkg::PLEN_W-1:0]         out_length
);

	localparam int XW = LENGTH_BITS + 4;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_AFTER_START,
		PH_BODY,
		PH_LENGTH,
		PH_PAYLOAD
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [7:0]              miss_cnt_q, miss_cnt_d;
	logic                    prev_delim_q, prev_delim_d;
	logic [LENGTH_BITS-1:0]  acc_q, acc_d;
	logic                    stopped_q, stopped_d;
	logic [LENGTH_BITS-1:0]  remain_q, remain_d;

	logic                    emit;
	logic                    clear;
	logic [dtd_pkg::KIND_W-1:0]   e_kind;
	logic [dtd_pkg::BYTE_W-1:0]   e_byte;
	logic [dtd_pkg::STATUS_W-1:0] e_status;

	logic [7:0]              miss_inc;
	logic [XW-1:0]           acc_x;
	logic [XW-1:0]           acc_mul;
	logic [LENGTH_BITS-1:0]  remain_dec;
	logic [31:0]             acc_w;

	assign q_pop = q_not_empty && (!out_valid || out_ready);

	assign miss_inc   = (miss_cnt_q == 8'hFF) ? miss_cnt_q : miss_cnt_q + 8'd1;
	assign acc_x      = {4'b0, acc_q};
	// acc * 10 + digit
	assign acc_mul    = (acc_x << 3) + (acc_x << 1) + XW'(q_rdata.digit);
	assign remain_dec = (remain_q != '0) ? remain_q - 1'b1 : remain_q;
	assign acc_w      = 32'(acc_q);

	always_comb begin
		phase_d      = phase_q;
		miss_cnt_d   = miss_cnt_q;
		prev_delim_d = prev_delim_q;
		acc_d        = acc_q;
		stopped_d    = stopped_q;
		remain_d     = remain_q;
		emit         = 1'b0;
		clear        = 1'b0;
		e_kind       = dtd_pkg::KIND_STATUS;
		e_byte       = '0;
		e_status     = dtd_pkg::ST_OK;

		if (q_rdata.miss) begin
			if (phase_q == PH_PAYLOAD) begin
				emit     = 1'b1;
				clear    = 1'b1;
				e_status = dtd_pkg::ST_PAYLOAD_MISS;
			end else if (miss_inc >= miss_limit) begin
				emit     = 1'b1;
				clear    = 1'b1;
				e_status = dtd_pkg::ST_MISS_LIMIT;
			end else begin
				miss_cnt_d = miss_inc;
			end
		end else begin
			case (phase_q)
				PH_HUNT: begin
					if (q_rdata.is_start) begin
						phase_d = PH_AFTER_START;
					end
				end
				PH_AFTER_START: begin
					if (!q_rdata.is_delim) begin
						emit     = 1'b1;
						clear    = 1'b1;
						e_status = dtd_pkg::ST_BAD_DELIM;
					end else begin
						phase_d      = PH_BODY;
						prev_delim_d = 1'b0;
					end
				end
				PH_BODY: begin
					if (q_rdata.is_fin) begin
						if (!prev_delim_q) begin
							emit     = 1'b1;
							clear    = 1'b1;
							e_status = dtd_pkg::ST_FIN_NO_DELIM;
						end else begin
							phase_d   = PH_LENGTH;
							acc_d     = '0;
							stopped_d = 1'b0;
						end
					end else begin
						prev_delim_d = q_rdata.is_delim;
						emit         = 1'b1;
						e_kind       = dtd_pkg::KIND_BODY;
						e_byte       = q_rdata.rx_byte;
					end
				end
				PH_LENGTH: begin
					if (q_rdata.is_dato) begin
						if (acc_q == '0) begin
							emit  = 1'b1;
							clear = 1'b1;
						end else begin
							remain_d = acc_q;
							phase_d  = PH_PAYLOAD;
						end
					end else if (!stopped_q) begin
						if (q_rdata.is_digit) begin
							acc_d = (acc_mul[XW-1:LENGTH_BITS] != '0) ? LEN_MAX :
									acc_mul[LENGTH_BITS-1:0];
						end else begin
							stopped_d = 1'b1;
						end
					end
				end
				PH_PAYLOAD: begin
					emit   = 1'b1;
					e_kind = dtd_pkg::KIND_PAYLOAD;
					e_byte = q_rdata.rx_byte;
					if (remain_dec == '0) begin
						clear = 1'b1;
					end else begin
						remain_d = remain_dec;
					end
				end
				default: begin
					clear = 1'b1;
				end
			endcase
		end

		if (clear) begin
			phase_d      = PH_HUNT;
			miss_cnt_d   = '0;
			prev_delim_d = 1'b0;
			acc_d        = '0;
			stopped_d    = 1'b0;
			remain_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			miss_cnt_q   <= '0;
			prev_delim_q <= 1'b0;
			acc_q        <= '0;
			stopped_q    <= 1'b0;
			remain_q     <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q      <= phase_d;
				miss_cnt_q   <= miss_cnt_d;
				prev_delim_q <= prev_delim_d;
				acc_q        <= acc_d;
				stopped_q    <= stopped_d;
				remain_q     <= remain_d;
				// pop only happens with the output slot free or draining
				out_valid    <= emit;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// record payload, loaded with the beat that produces it
	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_kind   <= e_kind;
			out_byte   <= e_byte;
			out_status <= e_status;
			out_last   <= clear;
			out_length <= acc_w[dtd_pkg::PLEN_W-1:0];
		end
	end

endmodule

`default_nettype wire

[sv/delimited_telegram_deframer.sv]
// Record path: an input beat is held in the beat queue, then its record in the output
// register that drives m_axis; a stalled output keeps the beat waiting in the queue.
// Throughput: one input beat per cycle; a stalled output holds the parser and the
// two-entry queue absorbs the beats in flight before s_axis_tready drops.
// Reset: arst_n clears the parser to hunting, empties the queue and sets
// miss_limit to 10.
// ---------------------------------------------------------------------------
// delimited_telegram_deframer: telegram deframer top level
// Classifier front end, beat queue and phase-machine back end.
// ---------------------------------------------------------------------------
`default_nettype none

module delimited_telegram_deframer #(
	parameter int LENGTH_BITS = dtd_pkg::LENGTH_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [7:0]                   cfg_wdata,      // miss_limit
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [7:0]                   s_axis_tdata,   // rx_byte
	input  wire logic [0:0]                   s_axis_tuser,   // miss
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// out_byte [7:0], status [10:8], payload_length [34:11], zero [39:35]
	output logic [dtd_pkg::TDATA_W-1:0]       m_axis_tdata,
	output logic [dtd_pkg::KIND_W-1:0]        m_axis_tuser,   // out_kind
	output logic                              m_axis_tlast    // frame_last
);

	localparam int PAD_W = dtd_pkg::TDATA_W - dtd_pkg::BYTE_W - dtd_pkg::STATUS_W
			- dtd_pkg::PLEN_W;

	logic [7:0]                    miss_limit_q;
	logic                          q_full;
	logic                          q_push;
	logic                          q_pop;
	logic                          q_not_empty;
	dtd_pkg::beat_t                q_wdata;
	dtd_pkg::beat_t                q_rdata;
	logic [dtd_pkg::BYTE_W-1:0]    out_byte;
	logic [dtd_pkg::STATUS_W-1:0]  out_status;
	logic [dtd_pkg::PLEN_W-1:0]    out_length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_limit_q <= 8'(dtd_pkg::MISS_LIMIT_RST);
		end else if (cfg_we) begin
			miss_limit_q <= cfg_wdata;
		end
	end

	dtd_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_wdata       (q_wdata)
	);

	dtd_queue #(
		.DEPTH (dtd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.rdata     (q_rdata)
	);

	dtd_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.miss_limit  (miss_limit_q),
		.q_not_empty (q_not_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_kind    (m_axis_tuser),
		.out_byte    (out_byte),
		.out_status  (out_status),
		.out_last    (m_axis_tlast),
		.out_length  (out_length)
	);

	assign m_axis_tdata = {{PAD_W{1'b0}}, out_length, out_status, out_byte};

endmodule

`default_nettype wire

[sv/dtd_checker.sv]
// ---------------------------------------------------------------------------
// dtd_checker: port-level checks
// Record consistency on the master side of the deframer.
// ---------------------------------------------------------------------------
`default_nettype none

module dtd_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         m_axis_tvalid,
	input wire logic                         m_axis_tready,
	input wire logic [dtd_pkg::TDATA_W-1:0]  m_axis_tdata,
	input wire logic [dtd_pkg::KIND_W-1:0]   m_axis_tuser,
	input wire logic                         m_axis_tlast
);

	// stalled beat must hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
			$stable(m_axis_tlast))
		else $error("m_axis beat changed while stalled");

	// status records always close a telegram and carry no byte
	a_status_rec: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == dtd_pkg::KIND_STATUS |->
			m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
		else $error("status record without tlast or with data byte");

	// only status records report an error code
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != dtd_pkg::KIND_STATUS |->
			m_axis_tdata[10:8] == dtd_pkg::ST_OK)
		else $error("data record with nonzero status");

	// a body byte never ends a telegram
	a_body_open: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == dtd_pkg::KIND_BODY |-> !m_axis_tlast)
		else $error("body beat marked last");

endmodule

bind delimited_telegram_deframer dtd_checker u_dtd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
